// ===== rtl/rmv_pkg.sv =====
// Package with shared types and constants for the running mean and variance block.
`timescale 1ns / 1ps
package rmv_pkg;

  localparam int M2_BITS = 63;
  localparam int CFG_BITS = 16;
  localparam logic [CFG_BITS-1:0] RESET_COUNT = 16'd100;
  localparam logic [M2_BITS-1:0] M2_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_MUL,
    S_DIV,
    S_ACC1,
    S_ACC2,
    S_EMIT
  } state_t;

endpackage

// ===== rtl/rmv_if.sv =====
// Sample and result channel interfaces for the running mean and variance block.
`timescale 1ns / 1ps
interface rmv_in_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_uv;

  modport source (output valid, output sample_uv, input ready);
  modport sink (input valid, input sample_uv, output ready);
endinterface

interface rmv_out_if #(parameter int SAMPLE_BITS = 24);
  import rmv_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mean_uv;
  logic [M2_BITS-1:0]            sum_sq_dev;
  logic                          saturated;

  modport source (output valid, output mean_uv, output sum_sq_dev, output saturated,
                  input ready);
  modport sink (input valid, input mean_uv, input sum_sq_dev, input saturated,
                output ready);
endinterface

// ===== rtl/rmv_mul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module rmv_mul #(
  parameter int WIDTH = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [WIDTH-1:0]   a,
  input  logic [WIDTH-1:0]   b,
  output logic               busy,
  output logic [2*WIDTH-1:0] prod
);
  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0]   mcand;
  logic [2*WIDTH-1:0] acc;
  logic [CW-1:0]      cnt;
  logic [WIDTH:0]     part_sum;

  always_comb begin
    if (acc[0]) begin
      part_sum = {1'b0, acc[2*WIDTH-1:WIDTH]} + {1'b0, mcand};
    end else begin
      part_sum = {1'b0, acc[2*WIDTH-1:WIDTH]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(WIDTH);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      acc   <= {{WIDTH{1'b0}}, b};
    end else if (cnt != '0) begin
      acc <= {part_sum, acc[WIDTH-1:1]};
    end
  end

  assign busy = (cnt != '0);
  assign prod = acc;
endmodule

// ===== rtl/rmv_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module rmv_div #(
  parameter int NUM_BITS = 50,
  parameter int DEN_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                busy,
  output logic [NUM_BITS-1:0] quot,
  output logic [DEN_BITS-1:0] rem
);
  localparam int CW = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] work;
  logic [DEN_BITS-1:0] part;
  logic [DEN_BITS-1:0] divisor;
  logic [CW-1:0]       cnt;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                ge;

  always_comb begin
    trial = {part, work[NUM_BITS-1]};
    ge    = (trial >= {1'b0, divisor});
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(NUM_BITS);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work    <= num;
      part    <= '0;
      divisor <= den;
    end else if (cnt != '0) begin
      work <= {work[NUM_BITS-2:0], ge};
      part <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
    end
  end

  assign busy = (cnt != '0);
  assign quot = work;
  assign rem  = part;
endmodule

// ===== rtl/running_mean_variance.sv =====
// Top level of the running mean and sum of squared deviations block.
// Samples arrive on the samples channel, one signed word per handshake, and
// are folded into a running mean and M2 by Welford's method. After
// sample_count samples (a count of zero acts as one) one word leaves on the
// results channel with the truncated mean, M2 and a saturation flag, and the
// running state clears for the next burst. The count is written through
// cfg_we and cfg_wdata; the user must write it only while the block is
// idle, as the block itself does not enforce this. It resets to 100. The
// serial multiplier forming delta squared runs alongside the divider
// forming the mean step, and then a second bit-serial divider divides
// delta squared by the sample index, one bit per cycle. The last sample
// of a burst also passes an emit state that loads the result word.
// The block takes a new sample once the previous one is folded in, even
// while a result word still waits. If the receiver stalls, the end of the
// next burst waits until the held word is taken.
// Reset clears the mean, M2, index and saturation flag, drops any pending
// result and restores the count.
`timescale 1ns / 1ps
module running_mean_variance #(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  rmv_in_if.sink                   samples,
  rmv_out_if.source                results,
  input  logic                     cfg_we,
  input  logic [rmv_pkg::CFG_BITS-1:0] cfg_wdata
);
  import rmv_pkg::*;

  localparam int MW = SAMPLE_BITS + 1;
  localparam int DW = 2 * MW;
  localparam int SUM_BITS = ((DW > M2_BITS) ? DW : M2_BITS) + 1;
  localparam int CMP_BITS = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

  state_t state, state_next;

  logic [CFG_BITS-1:0]    sample_count;
  logic [SAMPLE_BITS-1:0] mean_acc;
  logic [M2_BITS-1:0]     m2_acc;
  logic [COUNT_BITS-1:0]  sample_index;
  logic                   sat_flag;

  logic [MW-1:0]          mag;
  logic                   neg;
  logic [COUNT_BITS-1:0]  idx;
  logic [DW-1:0]          d2;
  logic [DW-1:0]          inc;
  logic                   emit;

  logic                   out_valid;
  logic [SAMPLE_BITS-1:0] out_mean;
  logic [M2_BITS-1:0]     out_m2;
  logic                   out_sat;

  logic                   accept;
  logic [MW-1:0]          delta;
  logic [COUNT_BITS-1:0]  idx_in;
  logic                   mul_start, mul_busy;
  logic                   mdiv_busy;
  logic                   ddiv_start, ddiv_busy;
  logic [DW-1:0]          prod;
  logic [MW-1:0]          mean_q;
  logic [COUNT_BITS-1:0]  mean_r;
  logic [DW-1:0]          d2_q;
  logic [COUNT_BITS-1:0]  d2_r;
  logic                   big;
  logic [SUM_BITS-1:0]    m2_sum;
  logic                   m2_over;
  logic                   out_free;

  rmv_mul #(.WIDTH(MW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mag),
    .b     (mag),
    .busy  (mul_busy),
    .prod  (prod)
  );

  rmv_div #(.NUM_BITS(MW), .DEN_BITS(COUNT_BITS)) u_mean_div (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .num   (mag),
    .den   (idx),
    .busy  (mdiv_busy),
    .quot  (mean_q),
    .rem   (mean_r)
  );

  rmv_div #(.NUM_BITS(DW), .DEN_BITS(COUNT_BITS)) u_m2_div (
    .clk   (clk),
    .rst   (rst),
    .start (ddiv_start),
    .num   (prod),
    .den   (idx),
    .busy  (ddiv_busy),
    .quot  (d2_q),
    .rem   (d2_r)
  );

  assign out_free = !out_valid || results.ready;
  assign accept   = samples.valid && samples.ready;
  assign delta    = {samples.sample_uv[SAMPLE_BITS-1], samples.sample_uv}
                    - {mean_acc[SAMPLE_BITS-1], mean_acc};
  assign idx_in   = sample_index + 1'b1;
  assign big      = ((mag >> 32) != '0);
  assign m2_sum   = SUM_BITS'(m2_acc) + SUM_BITS'(inc);
  assign m2_over  = big || (m2_sum > SUM_BITS'(M2_MAX));

  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    mul_start     = 1'b0;
    ddiv_start    = 1'b0;
    unique case (state)
      S_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        mul_start  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (!mul_busy && !mdiv_busy) begin
          ddiv_start = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (!ddiv_busy) begin
          state_next = S_ACC1;
        end
      end
      S_ACC1: begin
        state_next = S_ACC2;
      end
      S_ACC2: begin
        state_next = emit ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= RESET_COUNT;
    end else if (cfg_we) begin
      sample_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= delta[MW-1];
      mag <= delta[MW-1] ? (MW'(0) - delta) : delta;
      idx <= idx_in;
    end
    if (state == S_MUL && !mul_busy && !mdiv_busy) begin
      d2 <= prod;
    end
    if (state == S_ACC1) begin
      inc <= d2 - d2_q - DW'(d2_r != '0);
      emit <= (CMP_BITS'(idx) >= CMP_BITS'(sample_count)) || (idx == '1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_acc     <= '0;
      m2_acc       <= '0;
      sample_index <= '0;
      sat_flag     <= 1'b0;
    end else if (state == S_ACC1) begin
      mean_acc <= neg ? (mean_acc - mean_q[SAMPLE_BITS-1:0])
                      : (mean_acc + mean_q[SAMPLE_BITS-1:0]);
    end else if (state == S_ACC2) begin
      sample_index <= idx;
      if (idx != COUNT_BITS'(1)) begin
        if (m2_over) begin
          m2_acc   <= M2_MAX;
          sat_flag <= 1'b1;
        end else begin
          m2_acc <= m2_sum[M2_BITS-1:0];
        end
      end
    end else if (state == S_EMIT && out_free) begin
      mean_acc     <= '0;
      m2_acc       <= '0;
      sample_index <= '0;
      sat_flag     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out_mean <= mean_acc;
      out_m2   <= m2_acc;
      out_sat  <= sat_flag;
    end
  end

  assign results.valid      = out_valid;
  assign results.mean_uv    = out_mean;
  assign results.sum_sq_dev = out_m2;
  assign results.saturated  = out_sat;
endmodule
